// File: sv/wlsq_pkg.sv
`default_nettype none

package wlsq_pkg;

  // register file layout
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 8;

  localparam logic [CfgIdxW-1:0] RegTankSettle = 2'd0;
  localparam logic [CfgIdxW-1:0] RegDrainDetect = 2'd1;
  localparam logic [CfgIdxW-1:0] RegDrainLowClear = 2'd2;
  localparam logic [CfgIdxW-1:0] RegOvfSettle = 2'd3;

  // register reset values
  localparam logic [CfgDataW-1:0] TankSettleRst = 8'd30;
  localparam logic [CfgDataW-1:0] DrainDetectRst = 8'd20;
  localparam logic [CfgDataW-1:0] DrainLowClearRst = 8'd20;
  localparam logic [CfgDataW-1:0] OvfSettleRst = 8'd10;

  // tank level codes
  localparam logic [1:0] TankLow = 2'd0;
  localparam logic [1:0] TankMid = 2'd1;
  localparam logic [1:0] TankFull = 2'd2;
  localparam logic [1:0] TankError = 2'd3;

  // counter ceiling
  localparam logic [CfgDataW-1:0] CntMax = 8'hff;

  typedef struct packed {
    logic [CfgDataW-1:0] tank_settle_ticks;
    logic [CfgDataW-1:0] drain_detect_ticks;
    logic [CfgDataW-1:0] drain_low_clear_ticks;
    logic [CfgDataW-1:0] overflow_settle_ticks;
  } wlsq_cfg_t;

endpackage

`default_nettype wire

// File: sv/wlsq_tank.sv
`default_nettype none

module wlsq_tank import wlsq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                high_i,
  input  wire logic                low_i,
  input  wire logic [CfgDataW-1:0] settle_ticks_i,
  output logic [1:0]               level_d_o
);

  logic [CfgDataW-1:0] cnt_q, cnt_d, cnt_dec;
  logic [1:0]          prev_q, prev_d;
  logic [1:0]          acc_q, acc_d;
  logic [1:0]          code;

  // two-switch code
  always_comb begin
    if (!high_i) begin
      code = low_i ? TankMid : TankLow;
    end else begin
      code = low_i ? TankFull : TankError;
    end
  end

  // settle countdown, restarted on any change
  always_comb begin
    cnt_dec = (cnt_q != '0) ? cnt_q - 1'b1 : cnt_q;
    prev_d  = prev_q;
    acc_d   = acc_q;
    cnt_d   = cnt_dec;
    if (code != prev_q) begin
      prev_d = code;
      cnt_d  = settle_ticks_i;
    end else if (cnt_dec == '0) begin
      acc_d = code;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= TankLow;
      acc_q  <= TankLow;
    end else if (step_i) begin
      cnt_q  <= cnt_d;
      prev_q <= prev_d;
      acc_q  <= acc_d;
    end
  end

  assign level_d_o = acc_d;

endmodule

`default_nettype wire

// File: sv/wlsq_drain.sv
`default_nettype none

module wlsq_drain import wlsq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                sample_i,
  input  wire logic [CfgDataW-1:0] set_limit_i,
  input  wire logic [CfgDataW-1:0] clear_limit_i,
  output logic                     flag_d_o
);

  logic [CfgDataW-1:0] on_q, on_d, off_q, off_d;
  logic [CfgDataW-1:0] run_inc, run_limit;
  logic                flag_q, flag_d;

  // one saturating increment serves the active run
  always_comb begin
    run_limit = sample_i ? set_limit_i : clear_limit_i;
    run_inc   = sample_i ? on_q : off_q;
    if (run_inc != CntMax) begin
      run_inc = run_inc + 1'b1;
    end
    flag_d = flag_q;
    on_d   = on_q;
    off_d  = off_q;
    if (run_inc >= run_limit) begin
      run_inc = run_limit;
      flag_d  = sample_i;
    end
    if (sample_i) begin
      on_d  = run_inc;
      off_d = '0;
    end else begin
      on_d  = '0;
      off_d = run_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      on_q   <= '0;
      off_q  <= '0;
      flag_q <= 1'b0;
    end else if (step_i) begin
      on_q   <= on_d;
      off_q  <= off_d;
      flag_q <= flag_d;
    end
  end

  assign flag_d_o = flag_d;

endmodule

`default_nettype wire

// File: sv/wlsq_ovf.sv
`default_nettype none

module wlsq_ovf import wlsq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                step_i,
  input  wire logic                sample_i,
  input  wire logic [CfgDataW-1:0] settle_ticks_i,
  output logic                     detected_d_o
);

  logic [CfgDataW-1:0] delay_q, delay_d, delay_dec;
  logic                prev_q, prev_d;
  logic                pend_q, pend_d;
  logic                acc_q, acc_d;

  // change arms pending and restarts delay; expiry takes the sample
  always_comb begin
    delay_dec = (delay_q != '0) ? delay_q - 1'b1 : delay_q;
    delay_d   = delay_dec;
    prev_d    = prev_q;
    pend_d    = pend_q;
    acc_d     = acc_q;
    if (sample_i != prev_q) begin
      prev_d  = sample_i;
      pend_d  = 1'b1;
      delay_d = settle_ticks_i;
    end else if (delay_dec == '0 && pend_q) begin
      pend_d = 1'b0;
      acc_d  = sample_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q <= '0;
      prev_q  <= 1'b0;
      pend_q  <= 1'b0;
      acc_q   <= 1'b0;
    end else if (step_i) begin
      delay_q <= delay_d;
      prev_q  <= prev_d;
      pend_q  <= pend_d;
      acc_q   <= acc_d;
    end
  end

  assign detected_d_o = acc_d;

endmodule

`default_nettype wire

// File: sv/water_level_sensor_qualifier_core.sv
// channel   direction  handshake                payload
// --------  ---------  -----------------------  ----------------------------------------
// in        input      in_valid_i / in_stall_o  five switch samples, one request a tick
// out       output     out_valid_o / out_stall_i tank_level_o, drain_level_o, overflow_detected_o
// cfg       input      cfg_we_i                 cfg_index_i, cfg_data_i
//
// One request per cycle sustained while out_stall_i is low; a request is latched at accept,
// and its result is registered when it advances, so out_valid_o rises after both registers.
// The whole state update is one pass of counters and compares between the two registers.
// Reset clears all counters and flags and loads the register reset values.
// A stalled output holds its result; the input register still takes a request
// while the output slot is full but free to drain, and stalls only when both are held.

`default_nettype none

module water_level_sensor_qualifier_core import wlsq_pkg::*; (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic                tank_high_switch_i,
  input  wire logic                tank_low_switch_i,
  input  wire logic                drain_low_switch_i,
  input  wire logic                drain_high_switch_i,
  input  wire logic                overflow_switch_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               tank_level_o,
  output logic [1:0]               drain_level_o,
  output logic                     overflow_detected_o,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i
);

  wlsq_cfg_t cfg_q;

  logic       in_vld_q;
  logic       tank_high_q, tank_low_q, drain_low_q, drain_high_q, ovf_q;
  logic       out_vld_q;
  logic [1:0] tank_lvl_q, drain_lvl_q;
  logic       ovf_det_q;

  logic       accept, advance;
  logic [1:0] tank_lvl_d;
  logic       drain_low_flag_d, drain_high_flag_d, ovf_det_d;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.tank_settle_ticks     <= TankSettleRst;
      cfg_q.drain_detect_ticks    <= DrainDetectRst;
      cfg_q.drain_low_clear_ticks <= DrainLowClearRst;
      cfg_q.overflow_settle_ticks <= OvfSettleRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        RegTankSettle:    cfg_q.tank_settle_ticks     <= cfg_data_i;
        RegDrainDetect:   cfg_q.drain_detect_ticks    <= cfg_data_i;
        RegDrainLowClear: cfg_q.drain_low_clear_ticks <= cfg_data_i;
        RegOvfSettle:     cfg_q.overflow_settle_ticks <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // handshake
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign accept     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= accept || (in_vld_q && !advance);
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      tank_high_q  <= tank_high_switch_i;
      tank_low_q   <= tank_low_switch_i;
      drain_low_q  <= drain_low_switch_i;
      drain_high_q <= drain_high_switch_i;
      ovf_q        <= overflow_switch_i;
    end
  end

  // qualifiers
  wlsq_tank u_tank (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .high_i         (tank_high_q),
    .low_i          (tank_low_q),
    .settle_ticks_i (cfg_q.tank_settle_ticks),
    .level_d_o      (tank_lvl_d)
  );

  wlsq_drain u_drain_low (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .sample_i      (drain_low_q),
    .set_limit_i   (cfg_q.drain_detect_ticks),
    .clear_limit_i (cfg_q.drain_low_clear_ticks),
    .flag_d_o      (drain_low_flag_d)
  );

  wlsq_drain u_drain_high (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .sample_i      (drain_high_q),
    .set_limit_i   (cfg_q.drain_detect_ticks),
    .clear_limit_i (cfg_q.drain_detect_ticks),
    .flag_d_o      (drain_high_flag_d)
  );

  wlsq_ovf u_ovf (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .step_i         (advance),
    .sample_i       (ovf_q),
    .settle_ticks_i (cfg_q.overflow_settle_ticks),
    .detected_d_o   (ovf_det_d)
  );

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      tank_lvl_q  <= tank_lvl_d;
      drain_lvl_q <= {drain_high_flag_d, drain_low_flag_d};
      ovf_det_q   <= ovf_det_d;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign tank_level_o        = tank_lvl_q;
  assign drain_level_o       = drain_lvl_q;
  assign overflow_detected_o = ovf_det_q;

endmodule

`default_nettype wire

// File: tb/sv/water_level_sensor_qualifier_core_tb.sv
`default_nettype none

module water_level_sensor_qualifier_core_tb;
  import wlsq_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned SettleCycles = 4;

  // one tick of switch samples, msb first
  typedef struct packed {
    logic tank_high;
    logic tank_low;
    logic drain_low;
    logic drain_high;
    logic overflow;
  } switches_t;

  typedef struct packed {
    logic [1:0] tank;
    logic [1:0] drain;
    logic       overflow;
  } levels_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic                tank_high_switch_i = 1'b0;
  logic                tank_low_switch_i = 1'b0;
  logic                drain_low_switch_i = 1'b0;
  logic                drain_high_switch_i = 1'b0;
  logic                overflow_switch_i = 1'b0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [1:0]          tank_level_o;
  logic [1:0]          drain_level_o;
  logic                overflow_detected_o;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = RegTankSettle;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  water_level_sensor_qualifier_core u_top (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .tank_high_switch_i (tank_high_switch_i),
    .tank_low_switch_i  (tank_low_switch_i),
    .drain_low_switch_i (drain_low_switch_i),
    .drain_high_switch_i(drain_high_switch_i),
    .overflow_switch_i  (overflow_switch_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .tank_level_o       (tank_level_o),
    .drain_level_o      (drain_level_o),
    .overflow_detected_o(overflow_detected_o),
    .cfg_we_i           (cfg_we_i),
    .cfg_index_i        (cfg_index_i),
    .cfg_data_i         (cfg_data_i)
  );

  // clock
  always #1 clk_i = ~clk_i;

  // qualifier shadow state
  wlsq_cfg_t     cfg_q;
  logic [7:0]    tank_wait = '0;
  logic [1:0]    tank_last = TankLow;
  logic [1:0]    tank_code = TankLow;
  logic [7:0]    dl_on_run = '0;
  logic [7:0]    dl_off_run = '0;
  logic [7:0]    dh_on_run = '0;
  logic [7:0]    dh_off_run = '0;
  logic          dl_flag = 1'b0;
  logic          dh_flag = 1'b0;
  logic [7:0]    ovf_wait = '0;
  logic          ovf_last = 1'b0;
  logic          ovf_armed = 1'b0;
  logic          ovf_state = 1'b0;

  levels_t       expected_levels[$];
  int unsigned   mismatch_cnt = 0;
  int unsigned   cycle_cnt = 0;
  bit            no_idle = 1'b0;

  // sequence generator: tank pair, drain low, drain high, overflow
  logic [1:0]    grp_val [4];
  int unsigned   grp_hold [4];

  // saturating run step, clamped at its threshold
  function automatic logic [7:0] bump_run(input logic [7:0] run, input logic [7:0] lim);
    logic [7:0] r;
    r = (run < CntMax) ? run + 8'd1 : run;
    return (r >= lim) ? lim : r;
  endfunction

  task automatic update_drain(input logic sample, input logic [7:0] set_lim,
                              input logic [7:0] clr_lim, inout logic [7:0] on_run,
                              inout logic [7:0] off_run, inout logic flag);
    if (!sample) begin
      on_run = '0;
      off_run = bump_run(off_run, clr_lim);
      if (off_run >= clr_lim) flag = 1'b0;
    end else begin
      off_run = '0;
      on_run = bump_run(on_run, set_lim);
      if (on_run >= set_lim) flag = 1'b1;
    end
  endtask

  // advance the shadow state by one tick and queue the qualified levels
  task automatic qualify_tick(input switches_t sw);
    logic [1:0] code;
    levels_t    lv;
    // tank code settle
    if (tank_wait != 0) tank_wait = tank_wait - 8'd1;
    code = sw.tank_high ? (sw.tank_low ? TankFull : TankError)
                        : (sw.tank_low ? TankMid : TankLow);
    if (code != tank_last) begin
      tank_last = code;
      tank_wait = cfg_q.tank_settle_ticks;
    end else if (tank_wait == 0) begin
      tank_code = code;
    end
    // drain run counters
    update_drain(sw.drain_low, cfg_q.drain_detect_ticks, cfg_q.drain_low_clear_ticks,
                 dl_on_run, dl_off_run, dl_flag);
    update_drain(sw.drain_high, cfg_q.drain_detect_ticks, cfg_q.drain_detect_ticks,
                 dh_on_run, dh_off_run, dh_flag);
    // overflow delay
    if (ovf_wait != 0) ovf_wait = ovf_wait - 8'd1;
    if (sw.overflow != ovf_last) begin
      ovf_last = sw.overflow;
      ovf_armed = 1'b1;
      ovf_wait = cfg_q.overflow_settle_ticks;
    end else if (ovf_wait == 0 && ovf_armed) begin
      ovf_armed = 1'b0;
      ovf_state = sw.overflow;
    end
    lv.tank = tank_code;
    lv.drain = {dh_flag, dl_flag};
    lv.overflow = ovf_state;
    expected_levels.push_back(lv);
  endtask

  // send one request, predict at accept
  task automatic send_request(input switches_t sw);
    @(negedge clk_i);
    while (!no_idle && $urandom_range(0, 99) < 21) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    tank_high_switch_i <= sw.tank_high;
    tank_low_switch_i <= sw.tank_low;
    drain_low_switch_i <= sw.drain_low;
    drain_high_switch_i <= sw.drain_high;
    overflow_switch_i <= sw.overflow;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    qualify_tick(sw);
  endtask

  // hold off until every queued result is back and the pipe is empty
  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      RegTankSettle:    cfg_q.tank_settle_ticks = val;
      RegDrainDetect:   cfg_q.drain_detect_ticks = val;
      RegDrainLowClear: cfg_q.drain_low_clear_ticks = val;
      RegOvfSettle:     cfg_q.overflow_settle_ticks = val;
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [7:0] tank_t, input logic [7:0] detect_t,
                                input logic [7:0] clear_t, input logic [7:0] ovf_t);
    wait_idle();
    write_reg(RegTankSettle, tank_t);
    write_reg(RegDrainDetect, detect_t);
    write_reg(RegDrainLowClear, clear_t);
    write_reg(RegOvfSettle, ovf_t);
  endtask

  // mostly short thresholds, with the range ends now and then
  function automatic logic [7:0] pick_threshold();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd1;
    if (r == 1) return CntMax;
    return 8'($urandom_range(1, 16));
  endfunction

  function automatic int unsigned grp_limit(input int unsigned g);
    case (g)
      0: return cfg_q.tank_settle_ticks;
      1: return (cfg_q.drain_detect_ticks > cfg_q.drain_low_clear_ticks) ?
                cfg_q.drain_detect_ticks : cfg_q.drain_low_clear_ticks;
      2: return cfg_q.drain_detect_ticks;
      default: return cfg_q.overflow_settle_ticks;
    endcase
  endfunction

  // steady runs around the thresholds, with some pure noise ticks
  task automatic next_switches(output switches_t sw);
    if ($urandom_range(0, 99) < 10) begin
      sw = 5'($urandom_range(0, 31));
    end else begin
      for (int unsigned g = 0; g < 4; g++) begin
        if (grp_hold[g] == 0) begin
          grp_val[g] = 2'($urandom_range(0, 3));
          grp_hold[g] = $urandom_range(1, 2 * grp_limit(g) + 2);
        end
        grp_hold[g]--;
      end
      sw.tank_high = grp_val[0][1];
      sw.tank_low = grp_val[0][0];
      sw.drain_low = grp_val[1][0];
      sw.drain_high = grp_val[2][0];
      sw.overflow = grp_val[3][0];
    end
  endtask

  // field extremes at reset values, shortest thresholds, and zero thresholds
  task automatic test_directed();
    send_request(5'b00000);
    send_request(5'b00000);
    send_request(5'b11111);
    send_request(5'b11111);
    apply_settings(8'd1, 8'd1, 8'd1, 8'd1);
    for (int unsigned c = 0; c < 4; c++) begin
      repeat (2) send_request({c[1], c[1] ~^ c[0], c[0], c[1], c[0]});
    end
    apply_settings(8'd0, 8'd0, 8'd0, 8'd0);
    send_request(5'b11111);
    send_request(5'b11111);
    send_request(5'b00000);
    send_request(5'b10101);
    send_request(5'b01010);
    send_request(5'b01010);
  endtask

  // random settings per phase, one phase with no idling on either side
  task automatic test_random_phases(input int unsigned phases, input int unsigned per_phase);
    switches_t sw;
    for (int unsigned p = 0; p < phases; p++) begin
      apply_settings(pick_threshold(), pick_threshold(), pick_threshold(), pick_threshold());
      no_idle = (p == 1);
      repeat (per_phase) begin
        next_switches(sw);
        send_request(sw);
      end
      no_idle = 1'b0;
    end
  endtask

  // long drain runs at the top threshold so the run counters saturate
  task automatic test_saturation();
    switches_t sw;
    apply_settings(CntMax, CntMax, CntMax, CntMax);
    repeat (270) begin
      next_switches(sw);
      sw.drain_low = 1'b1;
      sw.drain_high = 1'b1;
      send_request(sw);
    end
    repeat (270) begin
      next_switches(sw);
      sw.drain_low = 1'b0;
      sw.drain_high = 1'b0;
      send_request(sw);
    end
  endtask

  // receiver stall
  always @(negedge clk_i) begin
    out_stall_i <= rst_ni && !no_idle && ($urandom_range(0, 99) < 21);
  end

  // compare each accepted result with the oldest prediction
  always @(posedge clk_i) begin : check_levels
    levels_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_levels.size() == 0) begin
        $error("unexpected result: tank_level %0d drain_level %0d overflow_detected %0d",
               tank_level_o, drain_level_o, overflow_detected_o);
        mismatch_cnt++;
      end else begin
        want = expected_levels.pop_front();
        if (tank_level_o !== want.tank) begin
          $error("tank_level: expected %0d, got %0d", want.tank, tank_level_o);
          mismatch_cnt++;
        end
        if (drain_level_o !== want.drain) begin
          $error("drain_level: expected %0d, got %0d", want.drain, drain_level_o);
          mismatch_cnt++;
        end
        if (overflow_detected_o !== want.overflow) begin
          $error("overflow_detected: expected %0d, got %0d", want.overflow,
                 overflow_detected_o);
          mismatch_cnt++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    cfg_q.tank_settle_ticks = TankSettleRst;
    cfg_q.drain_detect_ticks = DrainDetectRst;
    cfg_q.drain_low_clear_ticks = DrainLowClearRst;
    cfg_q.overflow_settle_ticks = OvfSettleRst;
    for (int unsigned g = 0; g < 4; g++) begin
      grp_val[g] = '0;
      grp_hold[g] = 0;
    end
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random_phases(3, 100);
    test_saturation();
    test_random_phases(4, 100);
    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

`default_nettype wire
